// ----- sv/aipd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aipd_pkg
// Shared types and constants of the +IPD stream deframer: beat payloads,
// register reset value and the characters of the frame header.
// ----------------------------------------------------------------------------
package aipd_pkg;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]  link_id;
		logic [15:0] payload_length;
		logic [15:0] peer_port;
		logic        port_present;
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        last;
	} out_t;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;
	localparam logic [16:0] ACC_SAT         = 17'h1FFFF;
	localparam logic [16:0] LINK_MAX        = 17'h000FF;
	localparam logic [16:0] PORT_MAX        = 17'h0FFFF;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

endpackage
`default_nettype wire

// ----- sv/aipd_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aipd_parser
// Header parser state machine: takes one registered beat per step, updates
// the parser state and forms at most one result for the same step.
// ----------------------------------------------------------------------------
module aipd_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         step,
	input  wire aipd_pkg::in_t item,
	output logic              res_valid,
	output aipd_pkg::out_t    res_data
);

	typedef enum logic [3:0] {
		PH_HUNT      = 4'd0,
		PH_LINK      = 4'd1,
		PH_LEN       = 4'd2,
		PH_EXTRA     = 4'd3,
		PH_IP        = 4'd4,
		PH_PORTCOMMA = 4'd5,
		PH_PORT      = 4'd6,
		PH_SKIP      = 4'd7,
		PH_DATA      = 4'd8
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  pm_q, pm_d;
	logic [16:0] acc_q, acc_d;
	logic        seen_q, seen_d;
	logic [7:0]  link_q, link_d;
	logic [15:0] len_q, len_d;
	logic [15:0] left_q, left_d;
	logic [15:0] port_q, port_d;
	logic        pflag_q, pflag_d;
	logic [15:0] max_payload_q;

	logic [7:0]  b;
	logic        is_dig;
	logic [20:0] acc_mul;
	logic [16:0] acc_add;
	logic [2:0]  hn_cur, hn_0;
	logic        hh_cur, hh_0;
	logic        do_hunt, do_resync, do_open;

	function automatic logic [7:0] prefix_char(logic [2:0] p);
		logic [7:0] c;
		case (p)
			3'd0:    c = aipd_pkg::CH_PLUS;
			3'd1:    c = aipd_pkg::CH_I;
			3'd2:    c = aipd_pkg::CH_P;
			3'd3:    c = aipd_pkg::CH_D;
			default: c = aipd_pkg::CH_COMMA;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] hunt_next(logic [2:0] pm, logic [7:0] x);
		logic [2:0] p;
		logic [2:0] r;
		p = (pm > 3'd4) ? 3'd0 : pm;
		if (x == prefix_char(p)) begin
			r = (p == 3'd4) ? 3'd0 : p + 3'd1;
		end else begin
			r = (x == aipd_pkg::CH_PLUS) ? 3'd1 : 3'd0;
		end
		return r;
	endfunction

	function automatic logic hunt_hit(logic [2:0] pm, logic [7:0] x);
		logic [2:0] p;
		p = (pm > 3'd4) ? 3'd0 : pm;
		return (p == 3'd4) && (x == aipd_pkg::CH_COMMA);
	endfunction

	assign b       = item.rx_byte;
	assign is_dig  = b inside {[8'h30:8'h39]};
	assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {17'd0, b[3:0]};
	assign acc_add = (acc_mul > {4'd0, aipd_pkg::ACC_SAT}) ? aipd_pkg::ACC_SAT
		: acc_mul[16:0];
	assign hn_cur  = hunt_next(pm_q, b);
	assign hh_cur  = hunt_hit(pm_q, b);
	assign hn_0    = hunt_next(3'd0, b);
	assign hh_0    = hunt_hit(3'd0, b);

	always_comb begin
		phase_d   = phase_q;
		pm_d      = pm_q;
		acc_d     = acc_q;
		seen_d    = seen_q;
		link_d    = link_q;
		len_d     = len_q;
		left_d    = left_q;
		port_d    = port_q;
		pflag_d   = pflag_q;
		res_valid = 1'b0;
		res_data  = '0;
		do_hunt   = 1'b0;
		do_resync = 1'b0;
		do_open   = 1'b0;

		case (phase_q)
			PH_HUNT: begin
				do_hunt = 1'b1;
			end
			PH_LINK: begin
				if (is_dig) begin
					acc_d  = acc_add;
					seen_d = 1'b1;
				end else if (seen_q && acc_q <= aipd_pkg::LINK_MAX
						&& b == aipd_pkg::CH_COMMA) begin
					link_d  = acc_q[7:0];
					acc_d   = '0;
					seen_d  = 1'b0;
					phase_d = PH_LEN;
				end else begin
					do_resync = 1'b1;
				end
			end
			PH_LEN: begin
				if (is_dig) begin
					acc_d  = acc_add;
					seen_d = 1'b1;
				end else if (!seen_q || acc_q > {1'b0, max_payload_q}) begin
					do_resync = 1'b1;
				end else begin
					len_d = acc_q[15:0];
					if (b == aipd_pkg::CH_COMMA) begin
						phase_d = PH_EXTRA;
					end else if (b == aipd_pkg::CH_COLON) begin
						do_open = 1'b1;
					end else begin
						do_resync = 1'b1;
					end
				end
			end
			PH_EXTRA: begin
				if (b == aipd_pkg::CH_QUOTE) begin
					phase_d = PH_IP;
				end else if (b == aipd_pkg::CH_COLON) begin
					do_open = 1'b1;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (b == aipd_pkg::CH_COLON) begin
					do_open = 1'b1;
				end
			end
			PH_IP: begin
				if (b == aipd_pkg::CH_QUOTE) begin
					phase_d = PH_PORTCOMMA;
				end
			end
			PH_PORTCOMMA: begin
				if (b == aipd_pkg::CH_COMMA) begin
					acc_d   = '0;
					seen_d  = 1'b0;
					phase_d = PH_PORT;
				end else begin
					do_resync = 1'b1;
				end
			end
			PH_PORT: begin
				if (is_dig) begin
					acc_d  = acc_add;
					seen_d = 1'b1;
				end else if (seen_q && acc_q <= aipd_pkg::PORT_MAX
						&& b == aipd_pkg::CH_COLON) begin
					port_d  = acc_q[15:0];
					pflag_d = 1'b1;
					do_open = 1'b1;
				end else begin
					do_resync = 1'b1;
				end
			end
			PH_DATA: begin
				res_valid = 1'b1;
				res_data.payload_byte = b;
				res_data.byte_valid   = 1'b1;
				if (left_q <= 16'd1) begin
					res_data.last = 1'b1;
					left_d  = '0;
					phase_d = PH_HUNT;
					pm_d    = '0;
				end else begin
					left_d = left_q - 16'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				pm_d    = '0;
				acc_d   = '0;
				seen_d  = 1'b0;
				link_d  = '0;
				len_d   = '0;
				left_d  = '0;
				port_d  = '0;
				pflag_d = 1'b0;
			end
		endcase

		// prefix hunt, also for a byte that broke a header
		if (do_hunt || do_resync) begin
			phase_d = PH_HUNT;
			acc_d   = '0;
			seen_d  = 1'b0;
			pm_d    = do_hunt ? hn_cur : hn_0;
			if (do_hunt ? hh_cur : hh_0) begin
				pm_d    = '0;
				link_d  = '0;
				len_d   = '0;
				port_d  = '0;
				pflag_d = 1'b0;
				left_d  = '0;
				phase_d = PH_LINK;
			end
		end

		if (do_open) begin
			acc_d  = '0;
			seen_d = 1'b0;
			if (len_d == 16'd0) begin
				res_valid = 1'b1;
				res_data.last = 1'b1;
				phase_d = PH_HUNT;
				pm_d    = '0;
			end else begin
				left_d  = len_d;
				phase_d = PH_DATA;
			end
		end

		res_data.link_id        = link_d;
		res_data.payload_length = len_d;
		res_data.peer_port      = port_d;
		res_data.port_present   = pflag_d;

		if (item.req_type == aipd_pkg::REQ_CLEAR) begin
			phase_d   = PH_HUNT;
			pm_d      = '0;
			acc_d     = '0;
			seen_d    = 1'b0;
			link_d    = '0;
			len_d     = '0;
			left_d    = '0;
			port_d    = '0;
			pflag_d   = 1'b0;
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			pm_q          <= '0;
			acc_q         <= '0;
			seen_q        <= 1'b0;
			link_q        <= '0;
			len_q         <= '0;
			left_q        <= '0;
			port_q        <= '0;
			pflag_q       <= 1'b0;
			max_payload_q <= aipd_pkg::MAX_PAYLOAD_RST;
		end else begin
			if (cfg_wr) begin
				max_payload_q <= cfg_data;
			end
			if (step) begin
				phase_q <= phase_d;
				pm_q    <= pm_d;
				acc_q   <= acc_d;
				seen_q  <= seen_d;
				link_q  <= link_d;
				len_q   <= len_d;
				left_q  <= left_d;
				port_q  <= port_d;
				pflag_q <= pflag_d;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/aipd_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aipd_out_reg
// Result register: holds one result beat until the sink takes it and tells
// the parser when a new result can be loaded.
// ----------------------------------------------------------------------------
module aipd_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire logic          load_valid,
	input  wire aipd_pkg::out_t load_data,
	output logic               free,
	output logic               out_valid,
	input  wire logic          out_ready,
	output aipd_pkg::out_t     out_data
);

	logic           valid_q;
	aipd_pkg::out_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load && load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && load_valid) begin
			data_q <= load_data;
		end
	end

endmodule
`default_nettype wire

// ----- sv/at_ipd_stream_deframer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// at_ipd_stream_deframer_unit
// +IPD stream deframer: parses modem frame headers and emits payload bytes.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while the result side keeps up. A beat waits
// in the input register until the parser steps on it; the parser updates its
// state from it in that step, and any result it causes is loaded into the
// output register at the end of that step, so a result passes the input
// register and then the output register before out_valid rises. The parser
// state update sets the rate. The cfg channel writes max_payload and is always
// ready; write it only while no frame is in flight.
module at_ipd_stream_deframer_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [15:0]   cfg_data,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire aipd_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output aipd_pkg::out_t     out_data
);

	logic           valid_s1;
	aipd_pkg::in_t  data_s1;
	logic           free;
	logic           step;
	logic           res_valid;
	aipd_pkg::out_t res_data;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && free;
	assign in_ready  = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	aipd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.step      (step),
		.item      (data_s1),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	aipd_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step),
		.load_valid (res_valid),
		.load_data  (res_data),
		.free       (free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

// ----- verif/at_ipd_stream_deframer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_ipd_stream_deframer_unit_tb
// Self-checking bench for the +IPD deframer. Modem bytes and clear requests
// are queued by the stimulus process and driven with random gaps. A parser
// copy inside the bench tracks every accepted beat and predicts the payload
// beats, which are compared field by field as they leave the block.
// ----------------------------------------------------------------------------
module at_ipd_stream_deframer_unit_tb;

	typedef enum logic [3:0] {
		PH_HUNT, PH_LINK, PH_LEN, PH_EXTRA, PH_IP, PH_PORT_SEP, PH_PORT, PH_SKIP, PH_DATA
	} parse_phase_t;

	typedef enum logic [1:0] {
		TAIL_NONE, TAIL_ADDR, TAIL_TEXT
	} header_tail_t;

	localparam logic [7:0]  CH_ZERO      = 8'h30;
	localparam logic [7:0]  CH_NINE      = 8'h39;
	localparam logic [39:0] IPD_PREFIX   = {aipd_pkg::CH_PLUS, aipd_pkg::CH_I,
		aipd_pkg::CH_P, aipd_pkg::CH_D, aipd_pkg::CH_COMMA};
	localparam int          QUIET_LIMIT  = 5000;
	localparam int          DRAIN_CYCLES = 4;
	localparam int          PHASE_BEATS  = 100;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [15:0]    cfg_data  = '0;
	logic           in_valid  = 1'b0;
	logic           in_ready;
	aipd_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	aipd_pkg::out_t out_data;

	aipd_pkg::in_t  rx_backlog[$];
	aipd_pkg::out_t expected_deliveries[$];
	aipd_pkg::in_t  next_beat;
	aipd_pkg::out_t oldest;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int          error_count   = 0;
	int          quiet_cycles  = 0;
	int          rx_beats      = 0;
	int          clear_beats   = 0;
	int          frames_done   = 0;
	int          empty_frames  = 0;
	int          data_bytes    = 0;
	int          cfg_writes    = 0;

	// parser copy
	parse_phase_t pr_phase;
	int           pr_prefix_cnt;
	logic [16:0]  pr_acc;
	logic         pr_seen;
	logic [7:0]   pr_link;
	logic [15:0]  pr_len;
	logic [15:0]  pr_left;
	logic [15:0]  pr_port;
	logic         pr_port_flag;
	logic [15:0]  pr_max_len;

	at_ipd_stream_deframer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		end
	endtask

	task automatic clear_parser_copy();
		pr_phase      = PH_HUNT;
		pr_prefix_cnt = 0;
		pr_acc        = '0;
		pr_seen       = 1'b0;
		pr_link       = '0;
		pr_len        = '0;
		pr_left       = '0;
		pr_port       = '0;
		pr_port_flag  = 1'b0;
	endtask

	function automatic logic is_dec(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	task automatic add_digit(input logic [7:0] b);
		int unsigned v;
		v = 32'(pr_acc) * 10 + 32'(b - CH_ZERO);
		pr_acc  = (v > 32'(aipd_pkg::ACC_SAT)) ? aipd_pkg::ACC_SAT : v[16:0];
		pr_seen = 1'b1;
	endtask

	task automatic start_number(input parse_phase_t nxt);
		pr_acc   = '0;
		pr_seen  = 1'b0;
		pr_phase = nxt;
	endtask

	task automatic hunt_prefix(input logic [7:0] b);
		if (pr_prefix_cnt > 4) begin
			pr_prefix_cnt = 0;
		end
		if (b == IPD_PREFIX[39 - 8 * pr_prefix_cnt -: 8]) begin
			pr_prefix_cnt++;
			if (pr_prefix_cnt == 5) begin
				pr_prefix_cnt = 0;
				pr_link       = '0;
				pr_len        = '0;
				pr_port       = '0;
				pr_port_flag  = 1'b0;
				pr_left       = '0;
				start_number(PH_LINK);
			end
		end else begin
			pr_prefix_cnt = (b == aipd_pkg::CH_PLUS) ? 1 : 0;
		end
	endtask

	// failing byte goes back through the prefix hunt
	task automatic resync(input logic [7:0] b);
		pr_phase      = PH_HUNT;
		pr_prefix_cnt = 0;
		pr_acc        = '0;
		pr_seen       = 1'b0;
		hunt_prefix(b);
	endtask

	task automatic deliver(input logic [7:0] data, input logic valid, input logic fin);
		aipd_pkg::out_t e;
		e.link_id        = pr_link;
		e.payload_length = pr_len;
		e.peer_port      = pr_port;
		e.port_present   = pr_port_flag;
		e.payload_byte   = data;
		e.byte_valid     = valid;
		e.last           = fin;
		expected_deliveries.push_back(e);
	endtask

	task automatic open_payload();
		pr_acc  = '0;
		pr_seen = 1'b0;
		if (pr_len == 0) begin
			deliver(8'h00, 1'b0, 1'b1);
			pr_phase      = PH_HUNT;
			pr_prefix_cnt = 0;
		end else begin
			pr_left  = pr_len;
			pr_phase = PH_DATA;
		end
	endtask

	task automatic deframe_byte(input aipd_pkg::in_t beat);
		logic [7:0] b;
		b = beat.rx_byte;
		if (beat.req_type == aipd_pkg::REQ_CLEAR) begin
			clear_parser_copy();
		end else begin
			case (pr_phase)
				PH_HUNT: hunt_prefix(b);
				PH_LINK: begin
					if (is_dec(b)) begin
						add_digit(b);
					end else if (pr_seen && pr_acc <= aipd_pkg::LINK_MAX
							&& b == aipd_pkg::CH_COMMA) begin
						pr_link = pr_acc[7:0];
						start_number(PH_LEN);
					end else begin
						resync(b);
					end
				end
				PH_LEN: begin
					if (is_dec(b)) begin
						add_digit(b);
					end else if (!pr_seen || pr_acc > {1'b0, pr_max_len}) begin
						resync(b);
					end else begin
						pr_len = pr_acc[15:0];
						if (b == aipd_pkg::CH_COMMA) begin
							pr_phase = PH_EXTRA;
						end else if (b == aipd_pkg::CH_COLON) begin
							open_payload();
						end else begin
							resync(b);
						end
					end
				end
				PH_EXTRA: begin
					if (b == aipd_pkg::CH_QUOTE) begin
						pr_phase = PH_IP;
					end else if (b == aipd_pkg::CH_COLON) begin
						open_payload();
					end else begin
						pr_phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (b == aipd_pkg::CH_COLON) begin
						open_payload();
					end
				end
				PH_IP: begin
					if (b == aipd_pkg::CH_QUOTE) begin
						pr_phase = PH_PORT_SEP;
					end
				end
				PH_PORT_SEP: begin
					if (b == aipd_pkg::CH_COMMA) begin
						start_number(PH_PORT);
					end else begin
						resync(b);
					end
				end
				PH_PORT: begin
					if (is_dec(b)) begin
						add_digit(b);
					end else if (pr_seen && pr_acc <= aipd_pkg::PORT_MAX
							&& b == aipd_pkg::CH_COLON) begin
						pr_port      = pr_acc[15:0];
						pr_port_flag = 1'b1;
						open_payload();
					end else begin
						resync(b);
					end
				end
				PH_DATA: begin
					if (pr_left <= 1) begin
						deliver(b, 1'b1, 1'b1);
						pr_left       = '0;
						pr_phase      = PH_HUNT;
						pr_prefix_cnt = 0;
					end else begin
						deliver(b, 1'b1, 1'b0);
						pr_left--;
					end
				end
				default: clear_parser_copy();
			endcase
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_beat = rx_backlog.pop_front();
				in_data  <= next_beat;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				pr_max_len = cfg_data;
				cfg_writes++;
			end
			if (in_valid && in_ready) begin
				deframe_byte(in_data);
				rx_beats++;
				if (in_data.req_type == aipd_pkg::REQ_CLEAR) begin
					clear_beats++;
				end
			end
			if (out_valid && out_ready) begin
				if (expected_deliveries.size() == 0) begin
					report_mismatch("payload beat with no frame byte pending");
				end else begin
					oldest = expected_deliveries.pop_front();
					check_field("link_id", out_data.link_id, oldest.link_id);
					check_field("payload_length", out_data.payload_length,
						oldest.payload_length);
					check_field("peer_port", out_data.peer_port, oldest.peer_port);
					check_field("port_present", out_data.port_present, oldest.port_present);
					check_field("payload_byte", out_data.payload_byte, oldest.payload_byte);
					check_field("byte_valid", out_data.byte_valid, oldest.byte_valid);
					check_field("last", out_data.last, oldest.last);
					if (oldest.byte_valid) begin
						data_bytes++;
					end else begin
						empty_frames++;
					end
					if (oldest.last) begin
						frames_done++;
					end
				end
			end
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
					(out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		aipd_pkg::in_t t;
		t.req_type = aipd_pkg::REQ_BYTE;
		t.rx_byte  = b;
		rx_backlog.push_back(t);
	endtask

	task automatic push_clear();
		aipd_pkg::in_t t;
		t.req_type = aipd_pkg::REQ_CLEAR;
		t.rx_byte  = 8'($urandom_range(255));
		rx_backlog.push_back(t);
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			push_byte(s[i]);
		end
	endtask

	function automatic string random_text();
		string pool;
		string s;
		int    n;
		int    i;
		pool = "okATxyz,-.0";
		s    = "";
		n    = $urandom_range(4);
		for (i = 0; i < n; i++) begin
			s = $sformatf("%s%c", s, pool[$urandom_range(pool.len() - 1)]);
		end
		return s;
	endfunction

	// header text, then n random payload bytes
	task automatic add_frame(input string link_s, input string len_s, input header_tail_t tail,
			input string port_s, input int unsigned n);
		string hdr;
		hdr = {"+IPD,", link_s, ",", len_s};
		case (tail)
			TAIL_ADDR: hdr = {hdr, ",\"", $sformatf("%0d.%0d.%0d.%0d", $urandom_range(255),
				$urandom_range(255), $urandom_range(255), $urandom_range(255)),
				"\",", port_s};
			TAIL_TEXT: hdr = {hdr, ",", random_text()};
			default: ;
		endcase
		push_text({hdr, ":"});
		repeat (n) push_byte($urandom_range(255));
	endtask

	function automatic string random_link();
		case ($urandom_range(5))
			0: return $sformatf("%0d", $urandom_range(255));
			1: return $sformatf("%03d", $urandom_range(255));
			default: return $sformatf("%0d", $urandom_range(9));
		endcase
	endfunction

	function automatic int unsigned random_length(input int unsigned limit);
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0) begin
			return 0;
		end else if (r == 1 && limit <= 40) begin
			return limit;
		end else if (r == 2) begin
			return $urandom_range((limit < 40) ? limit : 40);
		end
		return $urandom_range((limit < 12) ? limit : 12);
	endfunction

	task automatic broken_header(input int unsigned limit);
		case ($urandom_range(7))
			0: add_frame($sformatf("%0d", $urandom_range(999, 256)), "1", TAIL_NONE, "", 1);
			1: add_frame("1", (limit == 65535) ? "70000" : $sformatf("%0d", limit + 1),
				TAIL_NONE, "", 2);
			2: add_frame("", "2", TAIL_NONE, "", 2);
			3: add_frame("3", "", TAIL_TEXT, "", 1);
			4: add_frame("1", "1", TAIL_ADDR, $sformatf("%0d", $urandom_range(99999, 65536)), 1);
			5: push_text("+IPD,1,1,\"9.9.9.9\";5:x");
			6: begin
				push_text("+IP");
				add_frame(random_link(), "1", TAIL_NONE, "", 1);
			end
			default: add_frame("4", "123456789", TAIL_NONE, "", 1);
		endcase
	endtask

	// one random slice of traffic; beats counts everything but pure noise
	task automatic random_burst(input int unsigned limit, inout int unsigned beats);
		int unsigned pick;
		int unsigned start;
		int unsigned len;
		header_tail_t tail;
		start = rx_backlog.size();
		pick  = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(6, 1)) push_byte($urandom_range(255));
			return;
		end else if (pick < 12) begin
			push_clear();
		end else if (pick < 26) begin
			broken_header(limit);
		end else begin
			len  = random_length(limit);
			tail = header_tail_t'($urandom_range(2));
			add_frame(random_link(), $sformatf("%0d", len), tail,
				$sformatf("%0d", ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535)),
				len);
		end
		beats += rx_backlog.size() - start;
	endtask

	// wait until the sender is empty and every predicted beat has left the block
	task automatic settle();
		do @(posedge clk);
		while (rx_backlog.size() != 0 || in_valid || expected_deliveries.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_payload(input logic [15:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall,
			input logic [15:0] limit);
		int unsigned beats;
		write_max_payload(limit);
		send_idle_pct = idle;
		stall_pct     = stall;
		beats         = 0;
		while (beats < PHASE_BEATS / 2) random_burst(limit, beats);
		settle();
		while (beats < PHASE_BEATS) random_burst(limit, beats);
		settle();
	endtask

	initial begin
		clear_parser_copy();
		pr_max_len = aipd_pkg::MAX_PAYLOAD_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame, widest link and port, bare extra field closed at once
		add_frame("0", "0", TAIL_NONE, "", 0);
		add_frame("255", "1", TAIL_ADDR, "65535", 0);
		push_byte(8'hFF);
		push_text("+IPD,7,3,:");
		push_byte(8'h00);
		push_byte(aipd_pkg::CH_PLUS);
		push_byte(8'h80);
		// link over range, saturated length with '+' restarting the prefix
		push_text("+IPD,256,");
		push_text("+IPD,1,99999999+IPD,3,2,abc:");
		repeat (2) push_byte($urandom_range(255));
		// length over limit, port over range, missing port comma, missing digit
		push_text("+IPD,1,1025:");
		push_text("+IPD,9,4,\"1.1.1.1\",65536:");
		push_text("+IPD,9,1,\"x\"+IPD,9,1:z");
		push_text("+IPD,,1:");
		// clear in the middle of a header
		push_text("+IPD,2,5");
		push_clear();
		push_text(",1:Q+IPD,2,1:Q");
		settle();

		write_max_payload(16'd0);
		push_text("+IPD,4,0:+IPD,4,1:x+IPD,4,0,\"2.2.2.2\",0:");
		settle();

		run_phase(0, 0, 16'hFFFF);
		run_phase(86, 0, 16'd1);
		run_phase(0, 86, 16'd16);
		run_phase(15, 15, aipd_pkg::MAX_PAYLOAD_RST);

		$display("covered %0d rx beats incl. %0d clears; %0d frames closed, %0d empty, %0d bytes",
			rx_beats, clear_beats, frames_done, empty_frames, data_bytes);
		$display("max_payload written %0d times, from zero to full scale, under four gap mixes",
			cfg_writes);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/aipd_pkg.sv
sv/aipd_parser.sv
sv/aipd_out_reg.sv
sv/at_ipd_stream_deframer_unit.sv
verif/at_ipd_stream_deframer_unit_tb.sv
